FILE: rtl/prpd_pkg.sv
// prpd_pkg: shared types and constants of the pulse rate peak detector
// sequencer state type, register indexes, field widths, reset values and divider constants
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package prpd_pkg;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_FILT,
        S_ENV,
        S_MUL_THR,
        S_PEAK,
        S_MUL_MIN,
        S_MUL_MAX,
        S_MUL_TOL,
        S_DECIDE,
        S_DIV,
        S_TIMEOUT,
        S_OUT
    } prpd_state_t;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_ENV_MIN     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PEAK_FACTOR = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REFRACTORY  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BPM_MIN     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BPM_MAX     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD_TOL  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT     = 3'd6;

    localparam int CFG_DATA_W   = 25;
    localparam int ENV_MIN_W    = 25;
    localparam int FACTOR_W     = 10;
    localparam int REFRACT_W    = 12;
    localparam int BPM_W        = 9;
    localparam int TOL_W        = 8;
    localparam int TIMEOUT_W    = 14;

    localparam int TIME_W       = 32;
    localparam int RATE_W       = 13;
    localparam int COUNT_W      = 8;
    localparam int Q8_SHIFT     = 8;

    // reset values of the configuration registers
    localparam logic [ENV_MIN_W-1:0] ENV_MIN_RST    = 25'd2560;
    localparam logic [FACTOR_W-1:0]  FACTOR_RST     = 10'd128;
    localparam logic [REFRACT_W-1:0] REFRACT_RST    = 12'd250;
    localparam logic [BPM_W-1:0]     BPM_MIN_RST    = 9'd40;
    localparam logic [BPM_W-1:0]     BPM_MAX_RST    = 9'd200;
    localparam logic [TOL_W-1:0]     TOL_RST        = 8'd64;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST    = 14'd2500;

    // rate math: 60000 ms per minute, 960000 for the q4 quotient
    localparam int MS_PER_MIN = 60000;
    localparam int DIV_W      = 20;
    localparam logic [DIV_W-1:0] RATE_DIVIDEND = 20'd960000;
    localparam int DIV_CNT_W  = 5;
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = 5'd19;
    localparam logic [COUNT_W-1:0] COUNT_MAX  = 8'd255;
    localparam logic [COUNT_W-1:0] VALID_MIN  = 8'd2;

endpackage

`default_nettype wire

FILE: rtl/pulse_rate_peak_detector.sv
// pulse_rate_peak_detector: photoplethysmogram peak detection and heart rate
// each accepted sample runs the filter, envelope, threshold, peak and timeout steps to a result;
// a scored interval adds the scoring steps, and a good interval also runs the 20 step divider
// a new sample is taken only once the last result is loaded; a stalled result holds off the next sample
// reset (aresetn low, synchronous): registers back to defaults, state cleared
`timescale 1ns / 1ps
`default_nettype none

module pulse_rate_peak_detector #(
    parameter int LP_SHIFT    = 2,
    parameter int ENV_SHIFT   = 5,
    parameter int SAMPLE_BITS = 18,
    parameter int FRAC_BITS   = 8,
    localparam int IN_W = ((32 + SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // sample input stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [IN_W-1:0]                 s_tdata,   // time_ms, ir_sample
    // result output stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [15:0]                     m_tdata,   // pulse_valid, rate_q4
    // configuration write channel
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [prpd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [prpd_pkg::CFG_DATA_W-1:0] cfg_data
);
    import prpd_pkg::*;

    // fixed point widths
    localparam int FILT_W  = SAMPLE_BITS + FRAC_BITS;     // signed filter value
    localparam int ENV_W   = FILT_W - 1;                  // unsigned envelope
    localparam int MUL_A_W = (ENV_W > TIME_W) ? ENV_W : TIME_W;
    localparam int PROD_W  = MUL_A_W + FACTOR_W;

    // configuration registers
    logic [ENV_MIN_W-1:0] env_min_reg;
    logic [FACTOR_W-1:0]  factor_reg;
    logic [REFRACT_W-1:0] refract_reg;
    logic [BPM_W-1:0]     bpm_min_reg;
    logic [BPM_W-1:0]     bpm_max_reg;
    logic [TOL_W-1:0]     tol_reg;
    logic [TIMEOUT_W-1:0] timeout_reg;

    // sequencer
    prpd_state_t state_reg, state_next;

    // sample held for the duration of the work
    logic [TIME_W-1:0]        now_reg;
    logic signed [FILT_W-1:0] x_reg;

    // detector state
    logic signed [FILT_W-1:0] filt_reg;
    logic [ENV_W-1:0]         env_reg;
    logic signed [FILT_W-1:0] prev_one_reg;
    logic signed [FILT_W-1:0] prev_two_reg;
    logic [TIME_W-1:0]        prev_one_time_reg;
    logic [TIME_W-1:0]        last_peak_reg;
    logic [TIME_W-1:0]        last_gap_reg;
    logic [COUNT_W-1:0]       good_count_reg;
    logic [RATE_W-1:0]        rate_reg;
    logic                     valid_flag_reg;

    // interval scoring
    logic [TIME_W-1:0]    gap_reg;
    logic                 plaus_reg;
    logic [PROD_W-1:0]    prod_reg;

    // divider
    logic [TIME_W-1:0]    div_rem_reg;
    logic [DIV_W-1:0]     div_quo_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;

    // output register
    logic                 out_valid_reg;
    logic                 out_pulse_reg;
    logic [RATE_W-1:0]    out_rate_reg;

    // ------------------------------------------------------------------
    // handshakes
    // ------------------------------------------------------------------
    logic in_xfer;
    logic out_load;

    assign s_tready  = (state_reg == S_IDLE);
    assign in_xfer   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {2'b00, out_rate_reg, out_pulse_reg};
    // result register frees when empty or when the current result transfers
    assign out_load  = (state_reg == S_OUT) && (!out_valid_reg || m_tready);

    // ------------------------------------------------------------------
    // datapath: filter and envelope steps
    // ------------------------------------------------------------------
    logic signed [SAMPLE_BITS-1:0] in_sample;
    logic signed [FILT_W:0]        lp_diff;
    logic signed [FILT_W:0]        lp_sum;
    logic [FILT_W-1:0]             filt_mag;
    logic signed [FILT_W:0]        env_diff;
    logic signed [FILT_W:0]        env_sum;
    logic [ENV_W-1:0]              env_new;

    assign in_sample = $signed(s_tdata[TIME_W +: SAMPLE_BITS]);

    // one-pole low pass: result always lies between old value and input
    assign lp_diff = (FILT_W + 1)'(x_reg) - (FILT_W + 1)'(filt_reg);
    assign lp_sum  = (FILT_W + 1)'(filt_reg) + (lp_diff >>> LP_SHIFT);

    assign filt_mag = filt_reg[FILT_W-1] ? FILT_W'(-filt_reg) : FILT_W'(filt_reg);
    assign env_diff = $signed({1'b0, filt_mag}) - $signed({2'b00, env_reg});
    assign env_sum  = $signed({2'b00, env_reg}) + (env_diff >>> ENV_SHIFT);
    // envelope saturates at its largest value
    assign env_new  = env_sum[FILT_W-1] ? {ENV_W{1'b1}} : env_sum[ENV_W-1:0];

    // ------------------------------------------------------------------
    // shared multiplier: threshold, plausibility and tolerance products
    // ------------------------------------------------------------------
    logic [MUL_A_W-1:0]  mul_a;
    logic [FACTOR_W-1:0] mul_b;

    always_comb begin
        mul_a = MUL_A_W'(gap_reg);
        mul_b = FACTOR_W'(bpm_min_reg);
        unique case (state_reg)
            S_MUL_THR: begin
                mul_a = MUL_A_W'(env_reg);
                mul_b = factor_reg;
            end
            S_MUL_MAX: begin
                mul_b = FACTOR_W'(bpm_max_reg);
            end
            S_MUL_TOL: begin
                mul_a = MUL_A_W'(last_gap_reg);
                mul_b = FACTOR_W'(tol_reg);
            end
            default: begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // peak decision and interval scoring
    // ------------------------------------------------------------------
    logic [PROD_W-1:0] scaled;
    logic [PROD_W-1:0] env_min_ext;
    logic [PROD_W-1:0] thr;
    logic [PROD_W-1:0] prev_one_ext;
    logic              is_peak;
    logic [TIME_W-1:0] gap_now;
    logic              peak_taken;
    logic              score_interval;
    logic [TIME_W-1:0] gap_delta;
    logic              periodic;
    logic              amp_ok;
    logic              interval_ok;
    logic [COUNT_W-1:0] good_inc;
    logic [TIME_W-1:0] since_peak;
    logic              timed_out;
    logic [TIME_W:0]   rem_shift;
    logic [TIME_W:0]   rem_diff;
    logic              q_bit;

    assign scaled       = prod_reg >> Q8_SHIFT;
    assign env_min_ext  = PROD_W'(env_min_reg);
    assign thr          = (scaled > env_min_ext) ? scaled : env_min_ext;
    assign prev_one_ext = PROD_W'(unsigned'(prev_one_reg));
    // a local maximum of the filtered signal above the threshold
    assign is_peak = (prev_one_reg > prev_two_reg) && (prev_one_reg >= filt_reg)
                     && !prev_one_reg[FILT_W-1] && (prev_one_ext > thr);

    assign gap_now    = prev_one_time_reg - last_peak_reg;
    // first peak is always taken, later ones only past the refractory time
    assign peak_taken = is_peak &&
                        ((last_peak_reg == '0) || (gap_now >= TIME_W'(refract_reg)));
    assign score_interval = peak_taken && (last_peak_reg != '0);

    assign gap_delta = (gap_reg > last_gap_reg) ? (gap_reg - last_gap_reg)
                                                : (last_gap_reg - gap_reg);
    assign periodic  = (last_gap_reg == '0) ||
                       (PROD_W'({gap_delta, 8'h00}) <= prod_reg);
    assign amp_ok    = (PROD_W'(env_reg) >= env_min_ext);
    assign interval_ok = plaus_reg && periodic && amp_ok;
    assign good_inc  = (good_count_reg == COUNT_MAX) ? COUNT_MAX : good_count_reg + 1'b1;

    assign since_peak = now_reg - last_peak_reg;
    assign timed_out  = (last_peak_reg != '0) && (since_peak > TIME_W'(timeout_reg));

    // restoring divider step for 960000 / gap
    assign rem_shift = {div_rem_reg, div_quo_reg[DIV_W-1]};
    assign rem_diff  = rem_shift - {1'b0, gap_reg};
    assign q_bit     = !rem_diff[TIME_W];

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (in_xfer) begin
                    state_next = S_FILT;
                end
            end
            S_FILT:    state_next = S_ENV;
            S_ENV:     state_next = S_MUL_THR;
            S_MUL_THR: state_next = S_PEAK;
            S_PEAK: begin
                state_next = score_interval ? S_MUL_MIN : S_TIMEOUT;
            end
            S_MUL_MIN: state_next = S_MUL_MAX;
            S_MUL_MAX: state_next = S_MUL_TOL;
            S_MUL_TOL: state_next = S_DECIDE;
            S_DECIDE: begin
                state_next = interval_ok ? S_DIV : S_TIMEOUT;
            end
            S_DIV: begin
                if (div_cnt_reg == DIV_LAST) begin
                    state_next = S_TIMEOUT;
                end
            end
            S_TIMEOUT: state_next = S_OUT;
            S_OUT: begin
                if (out_load) begin
                    state_next = S_IDLE;
                end
            end
            default:   state_next = S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            env_min_reg <= ENV_MIN_RST;
            factor_reg  <= FACTOR_RST;
            refract_reg <= REFRACT_RST;
            bpm_min_reg <= BPM_MIN_RST;
            bpm_max_reg <= BPM_MAX_RST;
            tol_reg     <= TOL_RST;
            timeout_reg <= TIMEOUT_RST;
        end else if (cfg_valid && cfg_ready) begin
            // indexes past the list are dropped
            unique case (cfg_index)
                REG_ENV_MIN:     env_min_reg <= cfg_data[ENV_MIN_W-1:0];
                REG_PEAK_FACTOR: factor_reg  <= cfg_data[FACTOR_W-1:0];
                REG_REFRACTORY:  refract_reg <= cfg_data[REFRACT_W-1:0];
                REG_BPM_MIN:     bpm_min_reg <= cfg_data[BPM_W-1:0];
                REG_BPM_MAX:     bpm_max_reg <= cfg_data[BPM_W-1:0];
                REG_PERIOD_TOL:  tol_reg     <= cfg_data[TOL_W-1:0];
                REG_TIMEOUT:     timeout_reg <= cfg_data[TIMEOUT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // sample capture and working registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            now_reg <= s_tdata[TIME_W-1:0];
            // scale to fixed point with FRAC_BITS fraction bits
            x_reg   <= FILT_W'(in_sample) <<< FRAC_BITS;
        end
        prod_reg <= mul_a * mul_b;
        if (state_reg == S_PEAK) begin
            gap_reg <= gap_now;
        end
        if (state_reg == S_MUL_MAX) begin
            plaus_reg <= (gap_reg != '0) && (prod_reg <= PROD_W'(MS_PER_MIN));
        end else if (state_reg == S_MUL_TOL) begin
            plaus_reg <= plaus_reg && (prod_reg >= PROD_W'(MS_PER_MIN));
        end
        if (state_reg == S_DECIDE) begin
            div_rem_reg <= '0;
            div_quo_reg <= RATE_DIVIDEND;
        end else if (state_reg == S_DIV) begin
            div_rem_reg <= q_bit ? rem_diff[TIME_W-1:0] : rem_shift[TIME_W-1:0];
            div_quo_reg <= {div_quo_reg[DIV_W-2:0], q_bit};
        end
    end

    // ------------------------------------------------------------------
    // detector state
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            filt_reg          <= '0;
            env_reg           <= '0;
            prev_one_reg      <= '0;
            prev_two_reg      <= '0;
            prev_one_time_reg <= '0;
            last_peak_reg     <= '0;
            last_gap_reg      <= '0;
            good_count_reg    <= '0;
            rate_reg          <= '0;
            valid_flag_reg    <= 1'b0;
            div_cnt_reg       <= '0;
        end else begin
            unique case (state_reg)
                S_FILT: begin
                    filt_reg <= lp_sum[FILT_W-1:0];
                end
                S_ENV: begin
                    env_reg <= env_new;
                end
                S_PEAK: begin
                    // first peak only records its time
                    if (peak_taken && !score_interval) begin
                        last_peak_reg <= prev_one_time_reg;
                    end
                end
                S_DECIDE: begin
                    div_cnt_reg   <= '0;
                    last_gap_reg  <= gap_reg;
                    last_peak_reg <= prev_one_time_reg;
                    if (interval_ok) begin
                        good_count_reg <= good_inc;
                        valid_flag_reg <= (good_inc >= VALID_MIN);
                    end else begin
                        good_count_reg <= '0;
                        rate_reg       <= '0;
                        valid_flag_reg <= 1'b0;
                    end
                end
                S_DIV: begin
                    div_cnt_reg <= div_cnt_reg + 1'b1;
                    if (div_cnt_reg == DIV_LAST) begin
                        rate_reg <= {div_quo_reg[RATE_W-2:0], q_bit};
                    end
                end
                S_TIMEOUT: begin
                    // no peak for too long clears the result
                    if (timed_out) begin
                        valid_flag_reg <= 1'b0;
                        good_count_reg <= '0;
                        rate_reg       <= '0;
                        last_gap_reg   <= '0;
                    end
                    prev_two_reg      <= prev_one_reg;
                    prev_one_reg      <= filt_reg;
                    prev_one_time_reg <= now_reg;
                end
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // result register
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_pulse_reg <= valid_flag_reg;
            out_rate_reg  <= rate_reg;
        end
    end

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_valid_needs_two: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_flag_reg |-> (good_count_reg >= VALID_MIN))
        else $error("pulse valid without two good intervals");

    a_rate_needs_good: assert property (@(posedge aclk) disable iff (!aresetn)
        (good_count_reg == '0) |-> (rate_reg == '0))
        else $error("rate held with no good interval");

    a_div_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DIV) |-> (div_cnt_reg <= DIV_LAST))
        else $error("divider ran past its last step");

    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        in_xfer |=> (state_reg == S_FILT))
        else $error("accepted sample did not start the sequence");

    a_out_from_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> ($past(state_reg) == S_OUT))
        else $error("result raised outside the output step");

endmodule

`default_nettype wire

FILE: dv/pulse_rate_peak_detector_test.sv
`timescale 1ns / 1ps
// pulse_rate_peak_detector_test: self-checking bench for the pulse rate peak detector
// streams timestamped ir samples, writes the tuning registers between phases and
// scores every result against a cycle-free software tracker; needs prpd_pkg and the rtl top

module pulse_rate_peak_detector_test;
    import prpd_pkg::*;

    localparam int LP_SHIFT    = 2;
    localparam int ENV_SHIFT   = 5;
    localparam int SAMPLE_BITS = 18;
    localparam int FRAC_BITS   = 8;
    localparam int IN_W        = ((TIME_W + SAMPLE_BITS + 7) / 8) * 8;
    localparam int OUT_W       = 16;

    localparam longint FILT_MAX   = (longint'(1) << (SAMPLE_BITS + FRAC_BITS - 1)) - 1;
    localparam longint FILT_MIN   = -FILT_MAX - 1;
    localparam longint SAMPLE_MAX = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
    localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;
    localparam longint RATE_NUM_Q4 = 960000;   // 60000 ms per minute times 16

    localparam int SETTLE_CYCLES  = 48;        // covers the longest scored path, through the divider
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int MAX_REPORTS    = 100;

    typedef struct {
        logic [TIME_W-1:0]             stamp;
        logic signed [SAMPLE_BITS-1:0] ir;
    } ppg_sample_t;

    typedef struct {
        logic              pulse_valid;
        logic [RATE_W-1:0] rate_q4;
    } pulse_result_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_W-1:0]       s_tdata   = '0;   // time_ms, ir_sample, zero fill
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_W-1:0]      m_tdata;          // pulse_valid, rate_q4, zero fill
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // samples waiting for the driver and results waiting for the monitor
    ppg_sample_t   sample_q[$];
    pulse_result_t beat_expect_q[$];
    ppg_sample_t   in_flight;
    pulse_result_t result_want;

    // tracker copy of the detector state and of the register file
    longint                trk_filt;
    longint                trk_env;
    longint                trk_prev_one;
    longint                trk_prev_two;
    logic [TIME_W-1:0]     trk_prev_one_time;
    logic [TIME_W-1:0]     trk_last_peak;
    logic [TIME_W-1:0]     trk_last_gap;
    int unsigned           trk_good;
    logic [RATE_W-1:0]     trk_rate;
    logic                  trk_valid;
    logic [CFG_DATA_W-1:0] reg_shadow [7];

    logic [TIME_W-1:0] clock_ms;
    bit  idle_on;
    int  send_hold;
    int  take_hold;
    int  quiet_cycles;
    int  errors;
    int  samples_sent;
    int  results_seen;
    int  regs_written;
    int  intervals_scored;
    int  intervals_passed;
    bit  count_saturated;

    pulse_rate_peak_detector #(
        .LP_SHIFT    (LP_SHIFT),
        .ENV_SHIFT   (ENV_SHIFT),
        .SAMPLE_BITS (SAMPLE_BITS),
        .FRAC_BITS   (FRAC_BITS)
    ) u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 aclk = ~aclk;

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // mostly back-to-back, some short gaps, rarely a long one
    function automatic int pick_gap();
        int roll;
        if (!idle_on) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic reset_tracker();
        trk_filt          = 0;
        trk_env           = 0;
        trk_prev_one      = 0;
        trk_prev_two      = 0;
        trk_prev_one_time = '0;
        trk_last_peak     = '0;
        trk_last_gap      = '0;
        trk_good          = 0;
        trk_rate          = '0;
        trk_valid         = 1'b0;
        reg_shadow[REG_ENV_MIN]     = ENV_MIN_RST;
        reg_shadow[REG_PEAK_FACTOR] = FACTOR_RST;
        reg_shadow[REG_REFRACTORY]  = REFRACT_RST;
        reg_shadow[REG_BPM_MIN]     = BPM_MIN_RST;
        reg_shadow[REG_BPM_MAX]     = BPM_MAX_RST;
        reg_shadow[REG_PERIOD_TOL]  = TOL_RST;
        reg_shadow[REG_TIMEOUT]     = TIMEOUT_RST;
    endtask

    // advance the tracker by one sample and return the result the block should send
    function automatic pulse_result_t score_sample(input ppg_sample_t smp);
        longint x;
        longint mag;
        longint scaled;
        longint thr;
        longint env_min;
        longint gap_l;
        longint last_l;
        longint diff;
        longint quot;
        logic [TIME_W-1:0] gap;
        logic [TIME_W-1:0] since;
        logic plausible;
        logic periodic;
        logic amp_ok;
        logic peak;
        pulse_result_t res;

        env_min = longint'(reg_shadow[REG_ENV_MIN]);
        x = longint'(smp.ir) * (longint'(1) << FRAC_BITS);

        // one-pole filters, arithmetic shift rounds toward minus infinity
        trk_filt = clip(trk_filt + ((x - trk_filt) >>> LP_SHIFT), FILT_MIN, FILT_MAX);
        mag = (trk_filt < 0) ? -trk_filt : trk_filt;
        trk_env = clip(trk_env + ((mag - trk_env) >>> ENV_SHIFT), 0, FILT_MAX);

        scaled = (trk_env * longint'(reg_shadow[REG_PEAK_FACTOR])) >>> Q8_SHIFT;
        thr = (scaled > env_min) ? scaled : env_min;

        // the previous sample is the candidate peak
        peak = (trk_prev_one > trk_prev_two) && (trk_prev_one >= trk_filt)
            && (trk_prev_one > thr);

        if (peak) begin
            gap = trk_prev_one_time - trk_last_peak;
            if (trk_last_peak == '0 || gap >= reg_shadow[REG_REFRACTORY]) begin
                if (trk_last_peak != '0) begin
                    gap_l  = longint'(gap);
                    last_l = longint'(trk_last_gap);
                    plausible = (gap_l != 0)
                        && (longint'(reg_shadow[REG_BPM_MIN]) * gap_l <= MS_PER_MIN)
                        && (longint'(reg_shadow[REG_BPM_MAX]) * gap_l >= MS_PER_MIN);
                    periodic = 1'b1;
                    if (last_l > 0) begin
                        diff = (gap_l > last_l) ? gap_l - last_l : last_l - gap_l;
                        periodic = (diff <<< Q8_SHIFT)
                            <= longint'(reg_shadow[REG_PERIOD_TOL]) * last_l;
                    end
                    amp_ok = trk_env >= env_min;
                    intervals_scored++;
                    if (plausible && periodic && amp_ok) begin
                        if (trk_good < COUNT_MAX) trk_good++;
                        if (trk_good == COUNT_MAX) count_saturated = 1'b1;
                        quot = RATE_NUM_Q4 / gap_l;
                        trk_rate = quot[RATE_W-1:0];
                        intervals_passed++;
                    end else begin
                        trk_good = 0;
                        trk_rate = '0;
                    end
                    trk_last_gap = gap;
                    trk_valid = trk_good >= VALID_MIN;
                end
                // a peak at time zero lands here and still reads as no peak
                trk_last_peak = trk_prev_one_time;
            end
        end

        since = smp.stamp - trk_last_peak;
        if (trk_last_peak != '0 && since > reg_shadow[REG_TIMEOUT]) begin
            trk_valid    = 1'b0;
            trk_good     = 0;
            trk_rate     = '0;
            trk_last_gap = '0;
        end

        trk_prev_two      = trk_prev_one;
        trk_prev_one      = trk_filt;
        trk_prev_one_time = smp.stamp;

        res.pulse_valid = trk_valid;
        res.rate_q4     = trk_rate;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        errors++;
        if (errors <= MAX_REPORTS)
            $display("[%0t] result %0d: %s got %0d expected %0d",
                     $time, results_seen, what, got, want);
    endtask

    // sample driver: keeps tvalid high across back-to-back items
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                beat_expect_q.push_back(score_sample(in_flight));
                samples_sent++;
            end
            if (!s_tvalid || s_tready) begin
                if (send_hold > 0) begin
                    send_hold--;
                    s_tvalid <= 1'b0;
                end else if (sample_q.size() != 0) begin
                    in_flight = sample_q.pop_front();
                    s_tdata   <= IN_W'({in_flight.ir, in_flight.stamp});
                    s_tvalid  <= 1'b1;
                    send_hold = pick_gap();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result side back-pressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (take_hold > 0) begin
            take_hold--;
            m_tready <= 1'b0;
        end else begin
            if ($urandom_range(0, 5) == 0) take_hold = pick_gap();
            m_tready <= (take_hold == 0);
        end
    end

    // result monitor: every transfer is matched against the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (beat_expect_q.size() == 0) begin
                report_mismatch("result with nothing pending, rate_q4", m_tdata[RATE_W:1], 0);
            end else begin
                result_want = beat_expect_q.pop_front();
                if (m_tdata[0] !== result_want.pulse_valid)
                    report_mismatch("pulse_valid", m_tdata[0], result_want.pulse_valid);
                if (m_tdata[RATE_W:1] !== result_want.rate_q4)
                    report_mismatch("rate_q4", m_tdata[RATE_W:1], result_want.rate_q4);
            end
            results_seen++;
        end
    end

    // watchdog on cycles with no transfer on any channel
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles, %0d results still pending",
                     quiet_cycles, beat_expect_q.size());
            $display("Verification failed");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(value);
        do @(posedge aclk); while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
        reg_shadow[idx] = CFG_DATA_W'(value);
        regs_written++;
    endtask

    task automatic load_regs(input int unsigned env_min, input int unsigned factor,
                             input int unsigned refract, input int unsigned bpm_lo,
                             input int unsigned bpm_hi, input int unsigned tol,
                             input int unsigned tmo);
        write_reg(REG_ENV_MIN, env_min);
        write_reg(REG_PEAK_FACTOR, factor);
        write_reg(REG_REFRACTORY, refract);
        write_reg(REG_BPM_MIN, bpm_lo);
        write_reg(REG_BPM_MAX, bpm_hi);
        write_reg(REG_PERIOD_TOL, tol);
        write_reg(REG_TIMEOUT, tmo);
    endtask

    // block idle: nothing queued, nothing in flight, and the pipeline has drained
    task automatic wait_drained();
        while (sample_q.size() != 0 || s_tvalid || beat_expect_q.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic push_sample(input logic [TIME_W-1:0] stamp, input longint value);
        ppg_sample_t smp;
        longint v;
        v = clip(value, SAMPLE_MIN, SAMPLE_MAX);
        smp.stamp = stamp;
        smp.ir    = v[SAMPLE_BITS-1:0];
        sample_q.push_back(smp);
    endtask

    // two rising full-scale samples then a drop puts a peak exactly at t
    task automatic push_beat(input logic [TIME_W-1:0] t);
        push_sample(t - 2, SAMPLE_MAX);
        push_sample(t, SAMPLE_MAX);
        push_sample(t + 2, SAMPLE_MIN);
    endtask

    // triangle-shaped pulse wave with noise, the occasional time jump or step back
    task automatic push_rhythm(input int count);
        int     period;
        int     step_ms;
        longint amp;
        longint noise;
        longint ph;
        longint v;
        period  = $urandom_range(450, 1300);
        step_ms = $urandom_range(8, 30);
        amp     = $urandom_range(1500, 120000);
        noise   = amp / $urandom_range(8, 64);
        for (int i = 0; i < count; i++) begin
            case ($urandom_range(0, 49))
                0: clock_ms += $urandom_range(2000, 12000);
                1: clock_ms -= $urandom_range(1, 500);
                default: clock_ms += step_ms + $urandom_range(0, step_ms / 4);
            endcase
            ph = longint'(clock_ms % period);
            if (2 * ph < period)
                v = -amp + (4 * amp * ph) / period;
            else
                v = 3 * amp - (4 * amp * ph) / period;
            v += longint'($urandom_range(0, 2 * noise)) - noise;
            push_sample(clock_ms, v);
        end
    endtask

    // fast two-sample beats at about 150 bpm, steady enough to keep scoring good
    task automatic push_pulse_train(input int pairs);
        for (int i = 0; i < pairs; i++) begin
            clock_ms += $urandom_range(190, 210);
            push_sample(clock_ms, $urandom_range(80000, SAMPLE_MAX));
            clock_ms += $urandom_range(190, 210);
            push_sample(clock_ms, longint'($urandom_range(0, 4000)) - 2000);
        end
    endtask

    // unrelated samples: any value, any timestamp
    task automatic push_noise(input int count);
        longint v;
        for (int i = 0; i < count; i++) begin
            case ($urandom_range(0, 7))
                0: v = SAMPLE_MAX;
                1: v = SAMPLE_MIN;
                default: v = SAMPLE_MIN + longint'($urandom_range(0, 2 * SAMPLE_MAX + 1));
            endcase
            if ($urandom_range(0, 3) == 0)
                clock_ms = $urandom;
            else
                clock_ms += $urandom_range(0, 3000);
            push_sample(clock_ms, v);
        end
    endtask

    initial begin
        reset_tracker();
        idle_on = 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: peak at time zero, first interval, rate before valid, valid,
        // refractory reject, timeout, all-ones timestamp
        push_beat(32'd0);
        push_beat(32'd1000);
        push_beat(32'd1500);
        push_beat(32'd2000);
        push_beat(32'd2100);
        push_sample(32'd5200, 0);
        push_sample(32'hFFFF_FFFF, -1);
        wait_drained();

        // reset settings, realistic pulse wave
        idle_on  = 1'b1;
        clock_ms = 32'd10000;
        push_rhythm(90);
        wait_drained();

        // permissive end of every range; two beats 2 ms apart give a very short interval
        load_regs(0, 0, 0, 0, 300, 255, 10000);
        clock_ms += 1000;
        push_beat(clock_ms);
        push_beat(clock_ms + 2);
        clock_ms += 10;
        push_rhythm(70);
        push_noise(20);
        wait_drained();

        // restrictive end of every range: nothing crosses the floor, timeout at zero
        idle_on = 1'b0;
        load_regs(33554431, 1023, 4000, 300, 0, 0, 0);
        push_noise(30);
        push_rhythm(40);
        wait_drained();

        // reset values again, long steady train across the timestamp wrap so the
        // good-interval count saturates and valid holds on
        idle_on = 1'b1;
        load_regs(ENV_MIN_RST, FACTOR_RST, REFRACT_RST, BPM_MIN_RST, BPM_MAX_RST,
                  TOL_RST, TIMEOUT_RST);
        clock_ms = 32'hFFFF_0000;
        push_pulse_train(262);
        wait_drained();

        // random settings leaning toward ones where intervals get scored
        repeat (3) begin
            idle_on = ($urandom_range(0, 2) != 0);
            load_regs(($urandom_range(0, 9) == 0) ? $urandom_range(0, 33554431)
                                                   : $urandom_range(0, 6000),
                      $urandom_range(0, 1023),
                      ($urandom_range(0, 4) == 0) ? $urandom_range(0, 4000)
                                                   : $urandom_range(0, 600),
                      $urandom_range(0, 80),
                      $urandom_range(120, 300),
                      $urandom_range(0, 255),
                      ($urandom_range(0, 4) == 0) ? $urandom_range(0, 10000)
                                                   : $urandom_range(1500, 10000));
            push_rhythm(40);
            push_pulse_train(6);
            push_noise(6);
            wait_drained();
        end

        if (beat_expect_q.size() != 0)
            report_mismatch("results never sent", beat_expect_q.size(), 0);

        $display("run covered %0d samples, %0d results, %0d register writes",
                 samples_sent, results_seen, regs_written);
        $display("%0d intervals scored, %0d good, good count saturated: %0d",
                 intervals_scored, intervals_passed, count_saturated);
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("%0d mismatches", errors);
            $display("Verification failed");
        end
        $finish;
    end

endmodule
